>>> sv/lse_pkg.sv
// Shared types and constants for the LSB steganography extractor.
package lse_pkg;

   // Extraction methods held in the mode register.
   localparam logic [1:0] MODE_LSB1 = 2'd0;
   localparam logic [1:0] MODE_LSB4 = 2'd1;
   localparam logic [1:0] MODE_LSBI = 2'd2;

   // Message part codes on the result channel.
   localparam logic [1:0] PART_LENGTH = 2'd0;
   localparam logic [1:0] PART_BODY   = 2'd1;
   localparam logic [1:0] PART_EXT    = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_MODE      = 2'd0;
   localparam logic [1:0] REG_ENCRYPTED = 2'd1;
   localparam logic [1:0] REG_HEADER    = 2'd2;

   // Reset values of the registers.
   localparam logic [1:0] MODE_RESET      = MODE_LSB1;
   localparam logic       ENCRYPTED_RESET = 1'b0;
   localparam logic [9:0] HEADER_RESET    = 10'd54;

   // LSBI skips the data byte whose offset mod 3 is this value.
   localparam logic [1:0] LSBI_SKIP_OFFSET = 2'd2;
   // Number of pattern flags read in LSBI.
   localparam logic [2:0] FLAG_COUNT = 3'd4;
   // Number of bytes in the length field.
   localparam logic [31:0] LENGTH_BYTES = 32'd4;
   // Bits that make one message byte.
   localparam logic [3:0] BYTE_BITS = 4'd8;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Front phases: header skip, flag read, message bits.
   typedef enum logic [1:0] {
      FP_HEADER,
      FP_FLAGS,
      FP_DATA
   } front_phase_type;

   // Back phases: length field, body, extension, finished.
   typedef enum logic [1:0] {
      BP_LENGTH,
      BP_BODY,
      BP_EXT,
      BP_DONE
   } back_phase_type;

   // Configuration seen by the front.
   typedef struct packed {
      logic [1:0] mode;
      logic [9:0] header_bytes;
   } front_cfg_type;

   // One assembled byte in the queue; restart marks the first byte of a new image.
   typedef struct packed {
      logic [7:0] data;
      logic       restart;
   } queue_entry_type;

endpackage

>>> sv/lse_if.sv
// Valid/ready channel interfaces for cover bytes and recovered message bytes.
interface lse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] cover_byte;
   logic       first_byte;

   modport source (output valid, output cover_byte, output first_byte, input ready);
   modport sink (input valid, input cover_byte, input first_byte, output ready);
endinterface

interface lse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic [1:0] part;
   logic       last_byte;

   modport source (output valid, output message_byte, output part, output last_byte,
                   input ready);
   modport sink (input valid, input message_byte, input part, input last_byte,
                 output ready);
endinterface

>>> sv/lsb_steganography_extract_top.sv
// Top level of the LSB steganography extractor.
// Cover-image bytes enter on req_bus, one word per accepted valid/ready handshake;
// first_byte marks the first byte of a new image and restarts extraction.
// Recovered message bytes leave on rsp_bus with their part (length, body,
// extension) and a last mark on the final byte; later input is dropped until
// the next first_byte. The APB-style port (psel/penable/pwrite/paddr/pwdata)
// sets mode at 0x0, encrypted at 0x4 and the header length at 0x8; write only
// while the block is idle. pready is always high; reads return the register.
// Throughput is one cover byte per cycle while the queue has room. A message
// byte reaches rsp_bus through the queue and the output register: the front
// assembles it and writes it into the two-entry queue at the accepting edge,
// and the back moves it into the output register once that register is free.
// When the receiver stalls, the output register holds its word, the queue
// fills, and req_bus.ready falls once the queue is full.
// Synchronous reset sets the registers to mode LSB1, not encrypted, 54 header
// bytes, and begins a new image with the next byte.
module lsb_steganography_extract_top (
   input  logic         clock,
   input  logic         reset,
   lse_req_if.sink      req_bus,
   lse_rsp_if.source    rsp_bus,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic [1:0] mode_ff;
   logic       encrypted_ff;
   logic [9:0] header_ff;
   logic       csr_write;
   logic       in_accept, push, pop, q_full, q_not_empty;
   lse_pkg::front_cfg_type   front_cfg;
   lse_pkg::queue_entry_type push_entry, q_head;

   // Configuration registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= lse_pkg::MODE_RESET;
         encrypted_ff <= lse_pkg::ENCRYPTED_RESET;
         header_ff    <= lse_pkg::HEADER_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            lse_pkg::REG_MODE:      mode_ff      <= pwdata[1:0];
            lse_pkg::REG_ENCRYPTED: encrypted_ff <= pwdata[0];
            lse_pkg::REG_HEADER:    header_ff    <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (paddr[3:2])
         lse_pkg::REG_MODE:      prdata = {30'd0, mode_ff};
         lse_pkg::REG_ENCRYPTED: prdata = {31'd0, encrypted_ff};
         lse_pkg::REG_HEADER:    prdata = {22'd0, header_ff};
         default:                prdata = '0;
      endcase
   end

   // Input handshake: take a word whenever the queue has room.
   assign req_bus.ready = !q_full;
   assign in_accept = req_bus.valid && !q_full;
   assign front_cfg.mode = mode_ff;
   assign front_cfg.header_bytes = header_ff;

   lse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (front_cfg),
      .in_accept  (in_accept),
      .cover_byte (req_bus.cover_byte),
      .first_byte (req_bus.first_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   lse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   lse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .encrypted   (encrypted_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule

>>> sv/lse_front.sv
// Front end: skips the header, reads LSBI flags and assembles message bytes.
module lse_front (
   input  logic                     clock,
   input  logic                     reset,
   input  lse_pkg::front_cfg_type   cfg,
   input  logic                     in_accept,
   input  logic [7:0]               cover_byte,
   input  logic                     first_byte,
   output logic                     push,
   output lse_pkg::queue_entry_type push_entry
);

   lse_pkg::front_phase_type phase_ff, phase_in, cur_phase, eff_phase;
   logic [9:0] skip_ff, skip_in, cur_skip;
   logic [1:0] off_ff, off_in, cur_off, off_next;
   logic [3:0] flags_ff, flags_in, cur_flags;
   logic [2:0] fcnt_ff, fcnt_in, cur_fcnt, fcnt_inc;
   logic [7:0] acc_ff, acc_in, cur_acc, acc_sum;
   logic [3:0] bits_ff, bits_in, cur_bits, bits_sum;
   logic       pend_ff, pend_in;
   logic       lsbi_skip, lsbi_bit, byte_done;

   // A first byte restarts every piece of state before the byte is used.
   always_comb begin
      cur_phase = first_byte ? lse_pkg::FP_HEADER : phase_ff;
      cur_skip  = first_byte ? '0 : skip_ff;
      cur_off   = first_byte ? '0 : off_ff;
      cur_flags = first_byte ? '0 : flags_ff;
      cur_fcnt  = first_byte ? '0 : fcnt_ff;
      cur_acc   = first_byte ? '0 : acc_ff;
      cur_bits  = first_byte ? '0 : bits_ff;
   end

   // Phase that actually handles this byte once the header has run out.
   always_comb begin
      eff_phase = cur_phase;
      if (cur_phase == lse_pkg::FP_HEADER && cur_skip >= cfg.header_bytes) begin
         eff_phase = (cfg.mode == lse_pkg::MODE_LSBI) ? lse_pkg::FP_FLAGS : lse_pkg::FP_DATA;
      end
   end

   assign fcnt_inc = cur_fcnt + 3'd1;
   assign off_next = (cur_off >= 2'd2) ? 2'd0 : cur_off + 2'd1;
   assign lsbi_skip = (cfg.mode == lse_pkg::MODE_LSBI) && (cur_off == lse_pkg::LSBI_SKIP_OFFSET);
   assign lsbi_bit = cover_byte[0] ^ cur_flags[cover_byte[2:1]];

   // Next phase.
   always_comb begin
      case (eff_phase)
         lse_pkg::FP_HEADER: phase_in = lse_pkg::FP_HEADER;
         lse_pkg::FP_FLAGS:  phase_in = (fcnt_inc >= lse_pkg::FLAG_COUNT) ?
                                        lse_pkg::FP_DATA : lse_pkg::FP_FLAGS;
         default:            phase_in = lse_pkg::FP_DATA;
      endcase
   end

   // Shift the taken bits into the accumulator according to the mode.
   always_comb begin
      case (cfg.mode)
         lse_pkg::MODE_LSB4: begin
            acc_sum  = {cur_acc[3:0], cover_byte[3:0]};
            bits_sum = cur_bits + 4'd4;
         end
         lse_pkg::MODE_LSBI: begin
            acc_sum  = {cur_acc[6:0], lsbi_bit};
            bits_sum = cur_bits + 4'd1;
         end
         default: begin
            acc_sum  = {cur_acc[6:0], cover_byte[0]};
            bits_sum = cur_bits + 4'd1;
         end
      endcase
   end

   // Datapath updates per phase.
   always_comb begin
      skip_in   = cur_skip;
      off_in    = cur_off;
      flags_in  = cur_flags;
      fcnt_in   = cur_fcnt;
      acc_in    = cur_acc;
      bits_in   = cur_bits;
      byte_done = 1'b0;
      case (eff_phase)
         lse_pkg::FP_HEADER: begin
            skip_in = cur_skip + 10'd1;
         end
         lse_pkg::FP_FLAGS: begin
            flags_in = cur_flags | (4'(cover_byte[0]) << cur_fcnt[1:0]);
            fcnt_in  = fcnt_inc;
            off_in   = off_next;
         end
         default: begin
            off_in = off_next;
            if (!lsbi_skip) begin
               if (bits_sum >= lse_pkg::BYTE_BITS) begin
                  byte_done = 1'b1;
                  acc_in    = '0;
                  bits_in   = '0;
               end else begin
                  acc_in  = acc_sum;
                  bits_in = bits_sum;
               end
            end
         end
      endcase
   end

   // A restart is carried to the back with the next assembled byte.
   assign push = in_accept && byte_done;
   assign push_entry.data = acc_sum;
   assign push_entry.restart = pend_ff || first_byte;
   assign pend_in = push ? 1'b0 : (pend_ff || (in_accept && first_byte));

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lse_pkg::FP_HEADER;
         skip_ff  <= '0;
         off_ff   <= '0;
         flags_ff <= '0;
         fcnt_ff  <= '0;
         acc_ff   <= '0;
         bits_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (in_accept) begin
            phase_ff <= phase_in;
            skip_ff  <= skip_in;
            off_ff   <= off_in;
            flags_ff <= flags_in;
            fcnt_ff  <= fcnt_in;
            acc_ff   <= acc_in;
            bits_ff  <= bits_in;
         end
      end
   end

endmodule

>>> sv/lse_queue.sv
// Short queue of assembled bytes between the front and the back.
module lse_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  lse_pkg::queue_entry_type push_entry,
   input  logic                     pop,
   output logic                     full,
   output logic                     not_empty,
   output lse_pkg::queue_entry_type head
);

   localparam int PtrBits = (lse_pkg::QUEUE_DEPTH > 1) ? $clog2(lse_pkg::QUEUE_DEPTH) : 1;
   localparam int CountBits = $clog2(lse_pkg::QUEUE_DEPTH + 1);

   lse_pkg::queue_entry_type slot_ff [lse_pkg::QUEUE_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CountBits-1:0] count_ff, count_in;

   assign full      = (count_ff == CountBits'(lse_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   // Pointers wrap at the queue depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (32'(wr_ptr_ff) == lse_pkg::QUEUE_DEPTH - 1) ? '0
                         : wr_ptr_ff + PtrBits'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (32'(rd_ptr_ff) == lse_pkg::QUEUE_DEPTH - 1) ? '0
                         : rd_ptr_ff + PtrBits'(1);
         end
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The occupancy never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= lse_pkg::QUEUE_DEPTH)
      else $error("queue occupancy beyond depth");

   // A pop from an empty queue would hand out a stale byte.
   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

>>> sv/lse_back.sv
// Back end: tracks the length, body and extension parts and drives the results.
module lse_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     encrypted,
   input  logic                     q_not_empty,
   input  lse_pkg::queue_entry_type q_head,
   output logic                     pop,
   lse_rsp_if.source                rsp_bus
);

   lse_pkg::back_phase_type phase_ff, phase_in, cur_phase;
   logic [31:0] len_ff, len_in, cur_len;
   logic [31:0] cnt_ff, cnt_in, cur_cnt, cnt_inc;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff;
   logic [1:0]  out_part_ff, part_c;
   logic        out_last_ff, last_c, produce, out_load;
   logic [7:0]  data;

   assign data = q_head.data;
   assign pop  = q_not_empty && (!out_valid_ff || rsp_bus.ready);

   // A restart mark begins a new message before this byte is used.
   always_comb begin
      cur_phase = q_head.restart ? lse_pkg::BP_LENGTH : phase_ff;
      cur_len   = q_head.restart ? '0 : len_ff;
      cur_cnt   = q_head.restart ? '0 : cnt_ff;
   end

   assign cnt_inc = cur_cnt + 32'd1;

   // Next phase, length and byte count.
   always_comb begin
      phase_in = cur_phase;
      len_in   = cur_len;
      cnt_in   = cnt_inc;
      case (cur_phase)
         lse_pkg::BP_LENGTH: begin
            len_in = {cur_len[23:0], data};
            if (cnt_inc >= lse_pkg::LENGTH_BYTES) begin
               cnt_in = '0;
               if ({cur_len[23:0], data} != 32'd0) begin
                  phase_in = lse_pkg::BP_BODY;
               end else begin
                  phase_in = encrypted ? lse_pkg::BP_DONE : lse_pkg::BP_EXT;
               end
            end
         end
         lse_pkg::BP_BODY: begin
            if (cnt_inc == cur_len) begin
               cnt_in   = '0;
               phase_in = encrypted ? lse_pkg::BP_DONE : lse_pkg::BP_EXT;
            end
         end
         lse_pkg::BP_EXT: begin
            if (data == 8'd0) begin
               phase_in = lse_pkg::BP_DONE;
            end
         end
         default: begin
            cnt_in = cur_cnt;
         end
      endcase
   end

   // Result fields for this byte.
   always_comb begin
      produce = 1'b1;
      part_c  = lse_pkg::PART_LENGTH;
      last_c  = 1'b0;
      case (cur_phase)
         lse_pkg::BP_LENGTH: begin
            last_c = encrypted && (cnt_inc >= lse_pkg::LENGTH_BYTES)
                     && ({cur_len[23:0], data} == 32'd0);
         end
         lse_pkg::BP_BODY: begin
            part_c = lse_pkg::PART_BODY;
            last_c = encrypted && (cnt_inc == cur_len);
         end
         lse_pkg::BP_EXT: begin
            part_c = lse_pkg::PART_EXT;
            last_c = (data == 8'd0);
         end
         default: begin
            produce = 1'b0;
         end
      endcase
   end

   assign out_load = pop && produce;
   assign out_valid_in = out_load || (out_valid_ff && !rsp_bus.ready);

   // Message state and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lse_pkg::BP_LENGTH;
         len_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            len_ff   <= len_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_byte_ff <= data;
         out_part_ff <= part_c;
         out_last_ff <= last_c;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.message_byte = out_byte_ff;
   assign rsp_bus.part         = out_part_ff;
   assign rsp_bus.last_byte    = out_last_ff;

   // The last word of a message leaves the back finished.
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      out_load && last_c |=> phase_ff == lse_pkg::BP_DONE)
      else $error("last word without finishing the message");

   // A finished message only restarts through a restart mark.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      pop && !q_head.restart && phase_ff == lse_pkg::BP_DONE |-> !out_load)
      else $error("word produced after the message ended");

   // A waiting word is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_bus.ready |-> !pop)
      else $error("output word overwritten while stalled");

   // The body counter stays below the length while the body runs.
   a_body_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lse_pkg::BP_BODY |-> cnt_ff < len_ff)
      else $error("body count reached the length");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the LSB steganography extractor top level.
module testbench;

   // Cycles without any accepted word before the run is abandoned.
   localparam int QUIET_LIMIT = 1000;
   // Cycles allowed for a cover byte to clear the front and back stages.
   localparam int SETTLE_CYCLES = 6;
   // Random cover bytes wanted in the random part.
   localparam int RANDOM_ITEMS = 530;

   // Extraction phases tracked by the predictor.
   typedef enum logic [2:0] {
      EX_HEADER,
      EX_FLAGS,
      EX_LENGTH,
      EX_BODY,
      EX_EXT,
      EX_DONE
   } extract_phase_type;

   // One recovered message byte as it should leave the block.
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] part;
      logic       last;
   } message_word_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   lse_req_if req_bus ();
   lse_rsp_if rsp_bus ();

   lsb_steganography_extract_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Register copies held by the predictor.
   logic [1:0] cfg_mode      = lse_pkg::MODE_RESET;
   logic       cfg_encrypted = lse_pkg::ENCRYPTED_RESET;
   logic [9:0] cfg_header    = lse_pkg::HEADER_RESET;

   // Extraction state held by the predictor.
   extract_phase_type ex_phase;
   logic [9:0]     ex_skip;
   logic [1:0]     ex_off;
   logic [3:0]     ex_flags;
   logic [2:0]     ex_flag_cnt;
   logic [7:0]     ex_acc;
   logic [3:0]     ex_bits;
   logic [31:0]    ex_length;
   logic [31:0]    ex_count;

   message_word_type pending_message_bytes[$];
   int error_count   = 0;
   int items_sent    = 0;
   int burst_left    = 0;
   int quiet_cycles  = 0;
   logic first_pending = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Begin a new image in the predictor.
   function automatic void clear_extraction();
      ex_phase    = EX_HEADER;
      ex_skip     = '0;
      ex_off      = '0;
      ex_flags    = '0;
      ex_flag_cnt = '0;
      ex_acc      = '0;
      ex_bits     = '0;
      ex_length   = '0;
      ex_count    = '0;
   endfunction

   // Work out the message byte, if any, that one accepted cover byte completes.
   task automatic predict_cover(input logic [7:0] cb, input logic first);
      logic          skip_now;
      logic          bit_v;
      logic [7:0]    done_byte;
      message_word_type word;
      word = '0;
      if (first) clear_extraction();
      if (ex_phase == EX_DONE) return;
      if (ex_phase == EX_HEADER) begin
         if (ex_skip < cfg_header) begin
            ex_skip = ex_skip + 10'd1;
            return;
         end
         ex_phase = (cfg_mode == lse_pkg::MODE_LSBI) ? EX_FLAGS : EX_LENGTH;
      end
      if (ex_phase == EX_FLAGS) begin
         ex_flags[ex_flag_cnt[1:0]] = ex_flags[ex_flag_cnt[1:0]] | cb[0];
         ex_flag_cnt = ex_flag_cnt + 3'd1;
         ex_off = (ex_off >= 2'd2) ? 2'd0 : ex_off + 2'd1;
         if (ex_flag_cnt >= lse_pkg::FLAG_COUNT) ex_phase = EX_LENGTH;
         return;
      end
      // Gather message bits with the mode in force now.
      case (cfg_mode)
         lse_pkg::MODE_LSBI: begin
            skip_now = (ex_off == lse_pkg::LSBI_SKIP_OFFSET);
            ex_off = (ex_off >= 2'd2) ? 2'd0 : ex_off + 2'd1;
            if (skip_now) return;
            bit_v = cb[0] ^ ex_flags[cb[2:1]];
            ex_acc = {ex_acc[6:0], bit_v};
            ex_bits = ex_bits + 4'd1;
         end
         lse_pkg::MODE_LSB4: begin
            ex_off = (ex_off >= 2'd2) ? 2'd0 : ex_off + 2'd1;
            ex_acc = {ex_acc[3:0], cb[3:0]};
            ex_bits = ex_bits + 4'd4;
         end
         default: begin
            ex_off = (ex_off >= 2'd2) ? 2'd0 : ex_off + 2'd1;
            ex_acc = {ex_acc[6:0], cb[0]};
            ex_bits = ex_bits + 4'd1;
         end
      endcase
      if (ex_bits < lse_pkg::BYTE_BITS) return;
      done_byte = ex_acc;
      ex_acc = '0;
      ex_bits = '0;
      word.data = done_byte;
      // Sort the byte into its part of the message.
      if (ex_phase == EX_LENGTH) begin
         word.part = lse_pkg::PART_LENGTH;
         ex_length = {ex_length[23:0], done_byte};
         ex_count = ex_count + 32'd1;
         if (ex_count >= lse_pkg::LENGTH_BYTES) begin
            ex_count = '0;
            if (ex_length != 32'd0) begin
               ex_phase = EX_BODY;
            end else if (cfg_encrypted) begin
               word.last = 1'b1;
               ex_phase = EX_DONE;
            end else begin
               ex_phase = EX_EXT;
            end
         end
      end else if (ex_phase == EX_BODY) begin
         word.part = lse_pkg::PART_BODY;
         ex_count = ex_count + 32'd1;
         if (ex_count == ex_length) begin
            ex_count = '0;
            if (cfg_encrypted) begin
               word.last = 1'b1;
               ex_phase = EX_DONE;
            end else begin
               ex_phase = EX_EXT;
            end
         end
      end else begin
         word.part = lse_pkg::PART_EXT;
         ex_count = ex_count + 32'd1;
         if (done_byte == 8'd0) begin
            word.last = 1'b1;
            ex_phase = EX_DONE;
         end
      end
      pending_message_bytes.push_back(word);
   endtask

   // Offer one cover byte, wait for it to be taken, then maybe idle for a while.
   task automatic send_cover(input logic [7:0] cb, input logic first);
      logic f;
      int   gap;
      f = first | first_pending;
      first_pending = 1'b0;
      req_bus.valid      <= 1'b1;
      req_bus.cover_byte <= cb;
      req_bus.first_byte <= f;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predict_cover(cb, f);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Hide one message byte in cover bytes according to the current mode.
   task automatic send_message_byte(input logic [7:0] value);
      logic [7:0] cb;
      int         i;
      case (cfg_mode)
         lse_pkg::MODE_LSB4: begin
            cb = 8'($urandom_range(0, 255));
            send_cover({cb[7:4], value[7:4]}, 1'b0);
            cb = 8'($urandom_range(0, 255));
            send_cover({cb[7:4], value[3:0]}, 1'b0);
         end
         lse_pkg::MODE_LSBI: begin
            for (i = 7; i >= 0; i--) begin
               while (ex_off == lse_pkg::LSBI_SKIP_OFFSET) begin
                  send_cover(8'($urandom_range(0, 255)), 1'b0);
               end
               cb = 8'($urandom_range(0, 255));
               cb[0] = value[i] ^ ex_flags[cb[2:1]];
               send_cover(cb, 1'b0);
            end
         end
         default: begin
            for (i = 7; i >= 0; i--) begin
               cb = 8'($urandom_range(0, 255));
               cb[0] = value[i];
               send_cover(cb, 1'b0);
            end
         end
      endcase
   endtask

   // Hold the sender off until every expected word is out and the pipe is empty.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_message_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write a register once the block is idle, then read it back.
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] want;
      logic [31:0] got;
      wait_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (index)
         lse_pkg::REG_MODE:      cfg_mode = value[1:0];
         lse_pkg::REG_ENCRYPTED: cfg_encrypted = value[0];
         lse_pkg::REG_HEADER:    cfg_header = value[9:0];
         default: ;
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (index)
         lse_pkg::REG_MODE:      want = {30'd0, cfg_mode};
         lse_pkg::REG_ENCRYPTED: want = {31'd0, cfg_encrypted};
         default:                want = {22'd0, cfg_header};
      endcase
      if (got !== want) begin
         $error("register %0d readback: expected %h, actual %h", index, want, got);
         error_count++;
      end
   endtask

   task automatic set_config(input logic [1:0] mode_v, input logic enc_v, input int hdr);
      write_register(lse_pkg::REG_MODE, {30'd0, mode_v});
      write_register(lse_pkg::REG_ENCRYPTED, {31'd0, enc_v});
      write_register(lse_pkg::REG_HEADER, hdr);
   endtask

   // One image: header, flags in LSBI, length, body and extension, then ignored bytes.
   task automatic send_image(input logic [1:0] mode_v, input logic enc_v, input int hdr,
                             input logic [31:0] len, input int unsigned body_n,
                             input int ext_n, input int trail_n);
      int k;
      set_config(mode_v, enc_v, hdr);
      first_pending = 1'b1;
      for (k = 0; k < hdr; k++) send_cover(8'($urandom_range(0, 255)), 1'b0);
      if (mode_v == lse_pkg::MODE_LSBI) begin
         for (k = 0; k < 4; k++) send_cover(8'($urandom_range(0, 255)), 1'b0);
      end
      for (k = 3; k >= 0; k--) send_message_byte(len[8*k +: 8]);
      for (k = 0; k < body_n; k++) send_message_byte(8'($urandom_range(0, 255)));
      if (body_n == len && !enc_v) begin
         for (k = 0; k < ext_n; k++) send_message_byte(8'($urandom_range(1, 255)));
         send_message_byte(8'd0);
      end
      for (k = 0; k < trail_n; k++) send_cover(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // Random cover bytes with an occasional restart mark in among them.
   task automatic send_noise(input int n);
      int k;
      for (k = 0; k < n; k++) begin
         send_cover(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
   endtask

   // Right after reset the stream counts as a new image without a first byte mark.
   task automatic test_reset_without_first();
      int k;
      set_config(lse_pkg::MODE_LSB4, 1'b1, 0);
      for (k = 0; k < 4; k++) send_message_byte(8'h00);
      send_cover(8'h5A, 1'b0);
   endtask

   // Extremes of the cover byte, a one-byte body and an empty extension.
   task automatic test_field_extremes();
      set_config(lse_pkg::MODE_LSB4, 1'b0, 2);
      send_cover(8'h00, 1'b1);
      send_cover(8'hFF, 1'b0);
      send_message_byte(8'h00);
      send_message_byte(8'h00);
      send_message_byte(8'h00);
      send_message_byte(8'h01);
      send_message_byte(8'hFF);
      send_message_byte(8'h00);
      send_cover(8'hFF, 1'b0);
      send_cover(8'h00, 1'b0);
   endtask

   // Shorten the header while the block is still skipping it.
   task automatic test_header_change_during_skip();
      int k;
      set_config(lse_pkg::MODE_LSB4, 1'b1, 20);
      first_pending = 1'b1;
      for (k = 0; k < 10; k++) send_cover(8'($urandom_range(0, 255)), 1'b0);
      write_register(lse_pkg::REG_HEADER, 4);
      for (k = 0; k < 4; k++) send_message_byte(8'h00);
      send_noise(3);
   endtask

   // Switch modes partway through the message bits, surplus bits included.
   task automatic test_mode_change_mid_image();
      set_config(lse_pkg::MODE_LSB1, 1'b0, 0);
      send_cover(8'($urandom_range(0, 255)), 1'b1);
      send_noise(4);
      write_register(lse_pkg::REG_MODE, {30'd0, lse_pkg::MODE_LSB4});
      send_noise(3);
      write_register(lse_pkg::REG_MODE, {30'd0, lse_pkg::MODE_LSBI});
      send_noise(12);
      write_register(lse_pkg::REG_MODE, 32'd3);
      send_noise(10);
   endtask

   // Encrypted is taken at the end of the body, not at the start of the image.
   task automatic test_encrypted_change_mid_message();
      set_config(lse_pkg::MODE_LSB4, 1'b1, 1);
      first_pending = 1'b1;
      send_cover(8'($urandom_range(0, 255)), 1'b0);
      send_message_byte(8'h00);
      send_message_byte(8'h00);
      send_message_byte(8'h00);
      send_message_byte(8'h02);
      send_message_byte(8'($urandom_range(0, 255)));
      write_register(lse_pkg::REG_ENCRYPTED, 32'd0);
      send_message_byte(8'($urandom_range(0, 255)));
      send_message_byte(8'h41);
      send_message_byte(8'h00);
      set_config(lse_pkg::MODE_LSB4, 1'b0, 0);
      first_pending = 1'b1;
      send_message_byte(8'h00);
      send_message_byte(8'h00);
      send_message_byte(8'h00);
      send_message_byte(8'h01);
      write_register(lse_pkg::REG_ENCRYPTED, 32'd1);
      send_message_byte(8'($urandom_range(0, 255)));
      send_noise(2);
   endtask

   // A length near the top of its range, cut short by the next image.
   task automatic test_long_length();
      send_image(lse_pkg::MODE_LSB4, 1'b0, 2, 32'hFFFF_FFFF, 5, 0, 0);
      send_image(lse_pkg::MODE_LSB1, 1'b1, 1, 32'h0000_0001, 1, 0, 2);
   endtask

   // The longest header the register allows, shortened once skipping is under way.
   task automatic test_longest_header();
      int k;
      set_config(lse_pkg::MODE_LSB4, 1'b1, 1023);
      first_pending = 1'b1;
      for (k = 0; k < 40; k++) send_cover(8'($urandom_range(0, 255)), 1'b0);
      write_register(lse_pkg::REG_HEADER, 40);
      for (k = 0; k < 4; k++) send_message_byte(8'h00);
      send_cover(8'hFF, 1'b0);
   endtask

   // Mostly well-formed images with random settings and content, some noise.
   task automatic test_random_images();
      int          start;
      logic [31:0] len;
      int unsigned body_n;
      int          hdr;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         hdr = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
         body_n = len;
         if (len != 0 && $urandom_range(0, 7) == 0) body_n = $urandom_range(0, len - 1);
         send_image(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), hdr, len, body_n,
                    $urandom_range(0, 3), $urandom_range(0, 4));
         if ($urandom_range(0, 7) == 0) send_noise($urandom_range(3, 20));
      end
   endtask

   // Receiver: runs of ready and stalls of random length, some long.
   int ready_run  = 0;
   int ready_hold = 0;
   always @(posedge clock) begin
      if (ready_run > 0) begin
         rsp_bus.ready <= 1'b1;
         ready_run--;
      end else if (ready_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold--;
      end else begin
         rsp_bus.ready <= 1'($urandom_range(0, 1));
         ready_run  = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 40);
         ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 8);
      end
   end

   // Compare each accepted message word with the oldest expectation.
   always @(posedge clock) begin : check_output
      message_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_message_bytes.size() == 0) begin
            $error("unexpected message word: message_byte %h part %0d last_byte %0d",
                   rsp_bus.message_byte, rsp_bus.part, rsp_bus.last_byte);
            error_count++;
         end else begin
            want = pending_message_bytes.pop_front();
            if (rsp_bus.message_byte !== want.data) begin
               $error("message_byte: expected %h, actual %h", want.data, rsp_bus.message_byte);
               error_count++;
            end
            if (rsp_bus.part !== want.part) begin
               $error("part: expected %0d, actual %0d", want.part, rsp_bus.part);
               error_count++;
            end
            if (rsp_bus.last_byte !== want.last) begin
               $error("last_byte: expected %0d, actual %0d", want.last, rsp_bus.last_byte);
               error_count++;
            end
         end
      end
   end

   // Give up when neither channel has moved a word for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cover_byte = 8'd0;
      req_bus.first_byte = 1'b0;
      rsp_bus.ready      = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = 4'd0;
      pwdata             = 32'd0;
      clear_extraction();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_without_first();
      test_field_extremes();
      test_header_change_during_skip();
      test_mode_change_mid_image();
      test_encrypted_change_mid_message();
      test_long_length();
      test_longest_header();
      test_random_images();

      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

>>> sim.f
sv/lse_pkg.sv
sv/lse_if.sv
sv/lse_front.sv
sv/lse_queue.sv
sv/lse_back.sv
sv/lsb_steganography_extract_top.sv
dv/testbench.sv
